// ----- src/eeg_pkg.sv -----
// Shared types and constants for the headset packet parser.
// Result kinds, status codes, row codes and configuration indexes; no dependencies.
package eeg_pkg;

    typedef logic [3:0] t_kind;
    typedef logic [2:0] t_band;
    typedef logic [1:0] t_status;
    typedef logic [1:0] t_cfg_idx;

    localparam t_kind K_BATTERY = 4'd0;
    localparam t_kind K_RAW16   = 4'd6;
    localparam t_kind K_POWER   = 4'd7;
    localparam t_kind K_ASIC    = 4'd8;
    localparam t_kind K_RR      = 4'd9;
    localparam t_kind K_NONE    = 4'd10;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_CHECKSUM = 2'd1;
    localparam t_status ST_LENGTH   = 2'd2;

    localparam logic [7:0] C_RAW16  = 8'h80;
    localparam logic [7:0] C_POWER  = 8'h81;
    localparam logic [7:0] C_ASIC   = 8'h83;
    localparam logic [7:0] C_RR     = 8'h86;
    localparam logic [7:0] C_FIRST  = 8'h01;
    localparam logic [7:0] C_LAST1  = 8'h06;

    localparam logic [1:0] TOP_MASK = 2'b11;
    localparam logic [1:0] TOP_HIGH = 2'b10;
    localparam logic [1:0] TOP_LOW  = 2'b01;

    localparam t_cfg_idx CFG_MODE   = 2'd0;
    localparam t_cfg_idx CFG_SYNC   = 2'd1;
    localparam t_cfg_idx CFG_EXTEND = 2'd2;

    localparam logic [6:0] MAX_RESULTS = 7'd64;

endpackage

// ----- src/eeg_headset_packet_parser.sv -----
// Headset packet parser top level: framing, payload memory and row walker.
// Depends on eeg_pkg.

// Each received byte transfers while the parser is framing or in raw
// mode, provided the output register is free: every byte, whether or not it gives a
// result, waits while a result is held there. After a good checksum the parser stops
// taking bytes and walks the payload memory through its registered read port, with a
// check per row and a finishing step, and it waits when the result side stalls.
module eeg_headset_packet_parser #(
    parameter int MAX_PAYLOAD = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  eeg_pkg::t_cfg_idx     i_cfg_idx,
    input  logic [7:0]            i_cfg_data,
    input  logic                  i_rx_valid,
    output logic                  o_rx_ready,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output eeg_pkg::t_kind        o_kind,
    output eeg_pkg::t_band        o_band,
    output logic [31:0]           o_value,
    output eeg_pkg::t_status      o_status,
    output logic                  o_last
);
    import eeg_pkg::*;

    localparam int AW = $clog2(MAX_PAYLOAD);
    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    typedef enum logic [2:0] {
        P_SYNC1, P_SYNC2, P_LEN, P_DATA, P_CHECK, P_HIGH, P_LOW, P_WALK
    } t_phase;

    typedef enum logic [2:0] {
        W_EXT, W_VLEN, W_CHECK, W_VAL, W_FIN
    } t_walk;

    logic [7:0] r_mem [MAX_PAYLOAD];
    logic [7:0] r_mem_q;

    t_phase     r_phase;
    t_walk      r_walk;
    logic       r_mode;
    logic [7:0] r_sync, r_ext;
    logic [7:0] r_len, r_rcv, r_sum, r_prev;
    logic [7:0] r_idx, r_next_i, r_code, r_vlen;
    logic       r_wait, r_extd;
    logic [1:0] r_nb_m1, r_bcnt;
    t_band      r_band, r_last_band;
    t_kind      r_kind;
    logic [23:0] r_acc;
    logic [6:0] r_cnt;
    logic       r_pend_v;
    t_kind      r_pend_kind;
    t_band      r_pend_band;
    logic [31:0] r_pend_val;
    logic       r_ov, r_o_last;
    t_kind      r_o_kind;
    t_band      r_o_band;
    logic [31:0] r_o_val;
    t_status    r_o_st;

    logic       free, acc_in, dec_ok, row_done;
    logic [1:0] dec_nb_m1;
    t_band      dec_last_band;
    t_kind      dec_kind;
    logic [7:0] dec_need;
    logic [8:0] row_end;
    logic [31:0] val_next;
    logic       mem_we;

    assign free       = !r_ov || i_res_ready;
    assign o_rx_ready = (r_phase != P_WALK) && free;
    assign acc_in     = i_rx_valid && o_rx_ready;
    assign mem_we     = acc_in && (r_phase == P_DATA);
    assign row_end    = {1'b0, r_idx} + {1'b0, r_vlen};
    assign val_next   = {r_acc, r_mem_q};
    assign row_done   = (r_bcnt == r_nb_m1);

    assign o_res_valid = r_ov;
    assign o_kind      = r_o_kind;
    assign o_band      = r_o_band;
    assign o_value     = r_o_val;
    assign o_status    = r_o_st;
    assign o_last      = r_o_last;

    always_comb begin
        dec_nb_m1     = 2'd0;
        dec_last_band = 3'd0;
        dec_kind      = K_BATTERY;
        dec_need      = 8'd1;
        dec_ok        = 1'b0;
        if (r_code >= C_FIRST && r_code <= C_LAST1) begin
            dec_ok   = 1'b1;
            dec_kind = 4'(r_code - C_FIRST);
        end else begin
            case (r_code)
                C_RAW16, C_RR: begin
                    dec_ok    = 1'b1;
                    dec_kind  = (r_code == C_RAW16) ? K_RAW16 : K_RR;
                    dec_nb_m1 = 2'd1;
                    dec_need  = 8'd2;
                end
                C_POWER: begin
                    dec_ok        = 1'b1;
                    dec_kind      = K_POWER;
                    dec_nb_m1     = 2'd3;
                    dec_last_band = 3'd7;
                    dec_need      = 8'd32;
                end
                C_ASIC: begin
                    dec_ok        = 1'b1;
                    dec_kind      = K_ASIC;
                    dec_nb_m1     = 2'd2;
                    dec_last_band = 3'd7;
                    dec_need      = 8'd24;
                end
                default: dec_ok = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_rcv[AW-1:0]] <= i_rx_byte;
        end
        r_mem_q <= r_mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= P_SYNC1;
            r_mode   <= 1'b0;
            r_sync   <= 8'd170;
            r_ext    <= 8'd85;
            r_len    <= 8'd0;
            r_rcv    <= 8'd0;
            r_sum    <= 8'd0;
            r_prev   <= 8'd0;
            r_walk   <= W_EXT;
            r_wait   <= 1'b0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
            r_cnt    <= 7'd0;
        end else begin
            if (r_ov && i_res_ready) begin
                r_ov <= 1'b0;
            end
            if (acc_in) begin
                r_prev <= i_rx_byte;
                unique case (r_phase)
                    P_SYNC1: if (i_rx_byte == r_sync) r_phase <= P_SYNC2;
                    P_SYNC2: r_phase <= (i_rx_byte == r_sync) ? P_LEN : P_SYNC1;
                    P_LEN: begin
                        if (i_rx_byte == r_sync) begin
                            r_phase <= P_LEN;
                        end else if (i_rx_byte > MAX_LEN) begin
                            r_ov     <= 1'b1;
                            r_o_kind <= K_NONE;
                            r_o_band <= 3'd0;
                            r_o_val  <= 32'd0;
                            r_o_st   <= ST_LENGTH;
                            r_o_last <= 1'b1;
                            r_phase  <= P_SYNC1;
                        end else begin
                            r_len   <= i_rx_byte;
                            r_rcv   <= 8'd0;
                            r_sum   <= 8'd0;
                            r_phase <= (i_rx_byte == 8'd0) ? P_CHECK : P_DATA;
                        end
                    end
                    P_DATA: begin
                        r_rcv <= r_rcv + 8'd1;
                        r_sum <= r_sum + i_rx_byte;
                        if (r_rcv + 8'd1 >= r_len) r_phase <= P_CHECK;
                    end
                    P_CHECK: begin
                        if (i_rx_byte != ~r_sum) begin
                            r_ov     <= 1'b1;
                            r_o_kind <= K_NONE;
                            r_o_band <= 3'd0;
                            r_o_val  <= 32'd0;
                            r_o_st   <= ST_CHECKSUM;
                            r_o_last <= 1'b1;
                            r_phase  <= P_SYNC1;
                        end else begin
                            r_phase  <= P_WALK;
                            r_walk   <= W_EXT;
                            r_wait   <= 1'b0;
                            r_extd   <= 1'b0;
                            r_idx    <= 8'd0;
                            r_cnt    <= 7'd0;
                            r_pend_v <= 1'b0;
                        end
                    end
                    P_HIGH: if (i_rx_byte[7:6] == TOP_HIGH) r_phase <= P_LOW;
                    P_LOW: begin
                        if ((i_rx_byte[7:6] & TOP_MASK) == TOP_LOW) begin
                            r_ov     <= 1'b1;
                            r_o_kind <= K_RAW16;
                            r_o_band <= 3'd0;
                            r_o_val  <= {16'd0, r_prev, i_rx_byte};
                            r_o_st   <= ST_OK;
                            r_o_last <= 1'b1;
                        end
                        r_phase <= P_HIGH;
                    end
                    default: r_phase <= r_mode ? P_HIGH : P_SYNC1;
                endcase
            end else if (r_phase == P_WALK) begin
                unique case (r_walk)
                    W_EXT: begin
                        if (!r_wait) begin
                            if (r_idx >= r_len) r_walk <= W_FIN;
                            else r_wait <= 1'b1;
                        end else begin
                            r_wait <= 1'b0;
                            r_idx  <= r_idx + 8'd1;
                            if (r_mem_q == r_ext) begin
                                r_extd <= 1'b1;
                            end else begin
                                r_code <= r_mem_q;
                                if (r_mem_q >= C_RAW16) begin
                                    r_walk <= W_VLEN;
                                end else begin
                                    r_vlen <= 8'd1;
                                    r_walk <= W_CHECK;
                                end
                            end
                        end
                    end
                    W_VLEN: begin
                        if (!r_wait) begin
                            if (r_idx >= r_len) r_walk <= W_FIN;
                            else r_wait <= 1'b1;
                        end else begin
                            r_wait <= 1'b0;
                            r_idx  <= r_idx + 8'd1;
                            r_vlen <= r_mem_q;
                            r_walk <= W_CHECK;
                        end
                    end
                    W_CHECK: begin
                        if (row_end > {1'b0, r_len}) begin
                            r_walk <= W_FIN;
                        end else if (!r_extd && dec_ok && r_vlen >= dec_need) begin
                            r_next_i    <= row_end[7:0];
                            r_kind      <= dec_kind;
                            r_nb_m1     <= dec_nb_m1;
                            r_last_band <= dec_last_band;
                            r_bcnt      <= 2'd0;
                            r_band      <= 3'd0;
                            r_acc       <= 24'd0;
                            r_walk      <= W_VAL;
                        end else begin
                            r_idx  <= row_end[7:0];
                            r_extd <= 1'b0;
                            r_walk <= W_EXT;
                        end
                    end
                    W_VAL: begin
                        if (!r_wait) begin
                            r_wait <= 1'b1;
                        end else if (!row_done) begin
                            r_wait <= 1'b0;
                            r_idx  <= r_idx + 8'd1;
                            r_acc  <= val_next[23:0];
                            r_bcnt <= r_bcnt + 2'd1;
                        end else if (r_cnt >= MAX_RESULTS || !r_pend_v || free) begin
                            r_wait <= 1'b0;
                            r_idx  <= r_idx + 8'd1;
                            r_acc  <= 24'd0;
                            r_bcnt <= 2'd0;
                            if (r_cnt < MAX_RESULTS) begin
                                r_cnt       <= r_cnt + 7'd1;
                                r_pend_v    <= 1'b1;
                                r_pend_kind <= r_kind;
                                r_pend_band <= r_band;
                                r_pend_val  <= val_next;
                                if (r_pend_v) begin
                                    r_ov     <= 1'b1;
                                    r_o_kind <= r_pend_kind;
                                    r_o_band <= r_pend_band;
                                    r_o_val  <= r_pend_val;
                                    r_o_st   <= ST_OK;
                                    r_o_last <= 1'b0;
                                end
                            end
                            if (r_band == r_last_band) begin
                                r_idx  <= r_next_i;
                                r_extd <= 1'b0;
                                r_walk <= W_EXT;
                            end else begin
                                r_band <= r_band + 3'd1;
                            end
                        end
                    end
                    W_FIN: begin
                        if (!r_pend_v) begin
                            r_phase <= P_SYNC1;
                        end else if (free) begin
                            r_ov     <= 1'b1;
                            r_o_kind <= r_pend_kind;
                            r_o_band <= r_pend_band;
                            r_o_val  <= r_pend_val;
                            r_o_st   <= ST_OK;
                            r_o_last <= 1'b1;
                            r_pend_v <= 1'b0;
                            r_phase  <= P_SYNC1;
                        end
                    end
                    default: r_walk <= W_FIN;
                endcase
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MODE: begin
                        r_mode  <= i_cfg_data[0];
                        r_phase <= i_cfg_data[0] ? P_HIGH : P_SYNC1;
                    end
                    CFG_SYNC:   r_sync <= i_cfg_data;
                    CFG_EXTEND: r_ext  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_pend_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_phase == P_WALK))
        else $error("pending result outside walk");
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_RESULTS)
        else $error("result count above cap");
    a_idx_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == P_WALK && r_wait) |-> (r_idx < r_len))
        else $error("walk read beyond payload");
    a_fin_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == P_WALK && r_walk == W_FIN && r_pend_v && free && !i_cfg_we)
        |=> (r_ov && r_o_last))
        else $error("final walk result not flagged");
`endif

endmodule

// ----- tb/eeg_headset_packet_parser_test.sv -----
// Self-checking testbench for the headset packet parser: framed packets and raw pairs.
// Predicts decoded readings per transferred byte and compares them in order; needs eeg_pkg.
module eeg_headset_packet_parser_test;
    timeunit 1ns;
    timeprecision 1ps;
    import eeg_pkg::*;

    localparam int         MAX_PAYLOAD = 128;
    localparam int         LIMIT       = 400000;
    localparam int         SETTLE      = 400;
    localparam logic [7:0] C_SILENT    = 8'h07;
    localparam logic [7:0] C_UNKNOWN   = 8'h90;

    typedef logic [7:0] t_byte;
    typedef enum {P_SYNC1, P_SYNC2, P_LEN, P_DATA, P_CHECK, P_HIGH, P_LOW} t_phase;
    typedef struct {
        t_kind       kind;
        t_band       band;
        logic [31:0] value;
        t_status     status;
        logic        last;
    } t_reading;

    logic        i_clk, i_rst_n;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic [7:0]  i_cfg_data;
    logic        i_rx_valid, o_rx_ready;
    logic [7:0]  i_rx_byte;
    logic        o_res_valid, i_res_ready;
    t_kind       o_kind;
    t_band       o_band;
    logic [31:0] o_value;
    t_status     o_status;
    logic        o_last;

    eeg_headset_packet_parser u_top (.*);

    t_byte    tx_bytes[$];
    t_reading pending_readings[$];
    t_reading byte_readings[$];
    int       errors = 0;
    int       cycles = 0;
    bit       quiet = 0;
    bit       tx_pause = 0;
    int       hold_req = 0;
    int       hold_seen = 0;
    int       hold_cnt = 0;

    // parser model state
    bit     m_mode;
    t_byte  m_sync, m_ext;
    t_phase m_phase;
    t_byte  m_store[MAX_PAYLOAD];
    int     m_len, m_count;
    t_byte  m_sum, m_prev;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void add_reading(t_kind k, t_band bd, logic [31:0] v, t_status s);
        if (byte_readings.size() < int'(MAX_RESULTS))
            byte_readings.push_back('{k, bd, v, s, 1'b0});
    endfunction

    function automatic logic [31:0] row_value(int pos, int count);
        logic [31:0] v = 0;
        for (int k = 0; k < count; k++)
            v = (v << 8) | m_store[(pos + k) % MAX_PAYLOAD];
        return v;
    endfunction

    function automatic void decode_row(t_byte code, int pos, int vlen);
        if (code >= C_FIRST && code <= C_LAST1) begin
            if (vlen >= 1)
                add_reading(t_kind'(code - C_FIRST), 0, row_value(pos, 1), ST_OK);
        end else if (code == C_RAW16 || code == C_RR) begin
            if (vlen >= 2)
                add_reading(code == C_RAW16 ? K_RAW16 : K_RR, 0, row_value(pos, 2), ST_OK);
        end else if (code == C_POWER) begin
            if (vlen >= 32)
                for (int b = 0; b < 8; b++)
                    add_reading(K_POWER, t_band'(b), row_value(pos + 4 * b, 4), ST_OK);
        end else if (code == C_ASIC) begin
            if (vlen >= 24)
                for (int b = 0; b < 8; b++)
                    add_reading(K_ASIC, t_band'(b), row_value(pos + 3 * b, 3), ST_OK);
        end
    endfunction

    function automatic void walk_rows();
        int    i = 0;
        int    vlen;
        t_byte code;
        bit    ext;
        while (i < m_len) begin
            ext = 0;
            while (i < m_len && m_store[i] == m_ext) begin
                ext = 1;
                i++;
            end
            if (i >= m_len) break;
            code = m_store[i];
            i++;
            if (code >= 8'h80) begin
                if (i >= m_len) break;
                vlen = m_store[i];
                i++;
            end else begin
                vlen = 1;
            end
            if (i + vlen > m_len) break;
            if (!ext) decode_row(code, i, vlen);
            i += vlen;
        end
    endfunction

    function automatic void parse_byte(t_byte b);
        byte_readings.delete();
        case (m_phase)
            P_SYNC1: if (b == m_sync) m_phase = P_SYNC2;
            P_SYNC2: m_phase = (b == m_sync) ? P_LEN : P_SYNC1;
            P_LEN: begin
                if (b == m_sync) begin
                end else if (b > MAX_PAYLOAD) begin
                    add_reading(K_NONE, 0, 0, ST_LENGTH);
                    m_phase = P_SYNC1;
                end else begin
                    m_len   = b;
                    m_count = 0;
                    m_sum   = 0;
                    m_phase = (b == 0) ? P_CHECK : P_DATA;
                end
            end
            P_DATA: begin
                if (m_count < MAX_PAYLOAD) m_store[m_count] = b;
                m_count = (m_count + 1) & 8'hFF;
                m_sum   = m_sum + b;
                if (m_count >= m_len) m_phase = P_CHECK;
            end
            P_CHECK: begin
                m_phase = P_SYNC1;
                if (b != ~m_sum) add_reading(K_NONE, 0, 0, ST_CHECKSUM);
                else walk_rows();
            end
            P_HIGH: if ((b[7:6] & TOP_MASK) == TOP_HIGH) m_phase = P_LOW;
            P_LOW: begin
                if ((b[7:6] & TOP_MASK) == TOP_LOW) add_reading(K_RAW16, 0, {m_prev, b}, ST_OK);
                m_phase = P_HIGH;
            end
        endcase
        m_prev = b;
        if (byte_readings.size() > 0) byte_readings[$].last = 1;
        foreach (byte_readings[i]) pending_readings.push_back(byte_readings[i]);
    endfunction

    // byte driver; predicts each transfer as it happens
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 0;
        end else begin
            if (i_rx_valid && o_rx_ready) parse_byte(i_rx_byte);
            if (!i_rx_valid || o_rx_ready) begin
                if (tx_bytes.size() > 0 && !tx_pause && (quiet || $urandom_range(0, 99) >= 36)) begin
                    i_rx_valid <= 1;
                    i_rx_byte  <= tx_bytes.pop_front();
                end else begin
                    i_rx_valid <= 0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_cnt    <= 600;
            i_res_ready <= 0;
        end else if (hold_cnt > 0) begin
            hold_cnt    <= hold_cnt - 1;
            i_res_ready <= 0;
        end else begin
            i_res_ready <= quiet || $urandom_range(0, 99) >= 36;
        end
    end

    always @(posedge i_clk) begin
        t_reading e;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (pending_readings.size() == 0) begin
                errors++;
                $display("%0t: unexpected reading kind %0d value %h", $realtime, o_kind, o_value);
            end else begin
                e = pending_readings.pop_front();
                if (e.kind != o_kind || e.band != o_band || e.value != o_value
                        || e.status != o_status || e.last != o_last) begin
                    errors++;
                    $display("%0t: expected kind %0d band %0d value %h status %0d last %0d",
                             $realtime, e.kind, e.band, e.value, e.status, e.last);
                    $display("%0t: actual   kind %0d band %0d value %h status %0d last %0d",
                             $realtime, o_kind, o_band, o_value, o_status, o_last);
                end
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, t_byte data);
        @(posedge i_clk);
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_MODE: begin
                m_mode  = data[0];
                m_phase = m_mode ? P_HIGH : P_SYNC1;
            end
            CFG_SYNC:   m_sync = data;
            CFG_EXTEND: m_ext = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic drain();
        wait (tx_bytes.size() == 0 && !i_rx_valid && pending_readings.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic add_row(ref t_byte p[$], input t_byte code, input int vlen);
        p.push_back(code);
        if (code >= 8'h80) p.push_back(t_byte'(vlen));
        repeat (vlen) p.push_back(t_byte'($urandom_range(0, 255)));
    endtask

    task automatic send_packet(t_byte p[$], bit bad_sum);
        t_byte sum = 0;
        tx_bytes.push_back(m_sync);
        tx_bytes.push_back(m_sync);
        tx_bytes.push_back(t_byte'(p.size()));
        foreach (p[i]) begin
            tx_bytes.push_back(p[i]);
            sum += p[i];
        end
        tx_bytes.push_back(bad_sum ? ~sum ^ t_byte'($urandom_range(1, 255)) : ~sum);
    endtask

    task automatic random_packet();
        t_byte p[$];
        int    target;
        int    r;
        target = ($urandom_range(0, 9) == 0) ? $urandom_range(90, 140) : $urandom_range(0, 30);
        while (p.size() < target) begin
            r = $urandom_range(0, 9);
            case (r)
                0, 1, 2: add_row(p, t_byte'($urandom_range(C_FIRST, C_SILENT)), 1);
                3: add_row(p, $urandom_range(0, 1) ? C_RAW16 : C_RR, $urandom_range(2, 3));
                4: add_row(p, $urandom_range(0, 1) ? C_POWER : C_ASIC, $urandom_range(24, 33));
                5: begin
                    repeat ($urandom_range(1, 2)) p.push_back(m_ext);
                    add_row(p, t_byte'($urandom_range(C_FIRST, C_LAST1)), 1);
                end
                6: add_row(p, C_UNKNOWN | t_byte'($urandom_range(0, 15)), $urandom_range(0, 4));
                7: p.push_back(t_byte'($urandom_range(0, 255)));
                8: add_row(p, $urandom_range(0, 1) ? C_RAW16 : C_POWER, $urandom_range(0, 1));
                default: add_row(p, $urandom_range(0, 1) ? C_RAW16 : C_RR, 2);
            endcase
        end
        while (p.size() > MAX_PAYLOAD) void'(p.pop_back());
        if ($urandom_range(0, 19) == 0) begin
            tx_bytes.push_back(m_sync);
            tx_bytes.push_back(m_sync);
            tx_bytes.push_back(t_byte'($urandom_range(MAX_PAYLOAD + 1, 255)));
        end else begin
            send_packet(p, $urandom_range(0, 7) == 0);
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) tx_bytes.push_back(t_byte'($urandom_range(0, 255)));
    endtask

    task automatic random_framed(int n_bytes);
        while (tx_bytes.size() < n_bytes) random_packet();
    endtask

    task automatic random_raw(int n_pairs);
        repeat (n_pairs) begin
            if ($urandom_range(0, 4) == 0) begin
                tx_bytes.push_back(t_byte'($urandom_range(0, 255)));
            end else begin
                tx_bytes.push_back({TOP_HIGH, 6'($urandom_range(0, 63))});
                tx_bytes.push_back({TOP_LOW, 6'($urandom_range(0, 63))});
            end
        end
    endtask

    initial begin
        t_byte p[$];
        i_rst_n     = 0;
        i_cfg_we    = 0;
        i_cfg_idx   = CFG_MODE;
        i_cfg_data  = 0;
        i_rx_valid  = 0;
        i_rx_byte   = 0;
        i_res_ready = 0;
        m_mode  = 0;
        m_sync  = 8'd170;
        m_ext   = 8'd85;
        m_phase = P_SYNC1;
        m_len   = 0;
        m_count = 0;
        m_sum   = 0;
        m_prev  = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        // every row code, extremes of values, extra sync before the length
        tx_bytes.push_back(m_sync);
        for (t_byte c = C_FIRST; c <= C_SILENT; c++) begin
            p.push_back(c);
            p.push_back((c == C_FIRST) ? 8'h00 : 8'hFF);
        end
        add_row(p, C_RAW16, 2);
        add_row(p, C_RR, 2);
        send_packet(p, 0);
        p.delete();
        add_row(p, C_POWER, 32);
        add_row(p, C_ASIC, 24);
        p.push_back(m_ext);
        add_row(p, C_FIRST, 1);
        add_row(p, C_UNKNOWN, 1);
        add_row(p, C_RAW16, 1);
        add_row(p, C_RR, 3);
        p.push_back(C_POWER);
        p.push_back(8'd10);
        p.push_back(8'h5A);
        send_packet(p, 0);
        p.delete();
        send_packet(p, 0);
        p.push_back(m_ext);
        send_packet(p, 0);
        add_row(p, C_FIRST, 1);
        send_packet(p, 1);
        tx_bytes.push_back(m_sync);
        tx_bytes.push_back(m_sync);
        tx_bytes.push_back(t_byte'(MAX_PAYLOAD + 1));
        tx_bytes.push_back(m_sync);
        tx_bytes.push_back(m_sync);
        tx_bytes.push_back(8'hFF);
        p.delete();
        repeat (MAX_PAYLOAD / 2) add_row(p, C_LAST1 - 8'd2, 1);
        send_packet(p, 0);
        drain();

        random_framed(30);
        @(posedge i_clk);
        hold_req <= hold_req + 1;
        drain();

        write_reg(CFG_SYNC, 8'hFF);
        write_reg(CFG_EXTEND, 8'h00);
        quiet <= 1;
        random_framed(20);
        drain();
        quiet <= 0;

        write_reg(CFG_MODE, 8'd1);
        random_raw(15);
        @(posedge i_clk);
        wait (tx_bytes.size() < 15);
        tx_pause <= 1;
        wait (pending_readings.size() == 0);
        @(posedge i_clk);
        tx_pause <= 0;
        drain();

        write_reg(CFG_MODE, 8'd0);
        write_reg(CFG_SYNC, 8'h00);
        write_reg(CFG_EXTEND, 8'hFF);
        random_framed(20);
        drain();

        write_reg(CFG_SYNC, 8'd170);
        write_reg(CFG_EXTEND, 8'd85);
        random_framed(15);
        drain();

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ----- files.f -----
src/eeg_pkg.sv
src/eeg_headset_packet_parser.sv
tb/eeg_headset_packet_parser_test.sv
